// File: rtl/iolst_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iolst_pkg
// Shared types and constants for the I/O latency statistics tracker.
// ---------------------------------------------------------------------------
package iolst_pkg;

  localparam int FLIGHT_DEPTH_DEF = 64;
  localparam int GROUP_DEPTH_DEF  = 64;

  localparam logic [7:0] WRITE_CHAR   = 8'h57;
  localparam int         SECTOR_SHIFT = 9;

  localparam logic FUNC_ISSUE    = 1'b0;
  localparam logic FUNC_COMPLETE = 1'b1;

  localparam logic [2:0] ST_ISSUED      = 3'd0;
  localparam logic [2:0] ST_FLIGHT_FULL = 3'd1;
  localparam logic [2:0] ST_COMPLETED   = 3'd2;
  localparam logic [2:0] ST_UNMATCHED   = 3'd3;
  localparam logic [2:0] ST_GROUP_FULL  = 3'd4;

  typedef struct packed {
    logic        func;
    logic [63:0] sector;
    logic [63:0] group_id;
    logic [22:0] sector_count;
    logic [7:0]  direction_char;
    logic [63:0] now_ns;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] out_group_id;
    logic        out_is_write;
    logic [63:0] latency_ns;
    logic [63:0] total_bytes;
    logic [63:0] total_count;
    logic [63:0] total_latency_ns;
  } out_word_t;

  // result of a key search over a table
  typedef struct packed {
    logic hit;
    logic free;
  } search_t;

endpackage

// File: rtl/iolst_flight.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iolst_flight
// In-flight request table: key search over a memory, one entry per cycle.
// ---------------------------------------------------------------------------
module iolst_flight
  import iolst_pkg::*;
#(
  parameter int DEPTH = FLIGHT_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   key,
  output logic          done,
  output search_t       res,
  output logic [AW-1:0] slot,
  output logic [63:0]   rd_start,
  output logic [63:0]   rd_group,
  output logic [31:0]   rd_size,
  output logic          rd_write,
  input  logic          wr_en,
  input  logic          wr_valid,
  input  logic [AW-1:0] wr_addr,
  input  logic [63:0]   wr_sector,
  input  logic [63:0]   wr_start,
  input  logic [63:0]   wr_group,
  input  logic [31:0]   wr_size,
  input  logic          wr_write
);

  localparam int EW = 64 + 64 + 64 + 32 + 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [EW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [EW-1:0] rdata;
  logic [AW-1:0] ptr;
  logic [AW-1:0] rd_ptr;
  logic          busy;
  logic          chk;
  logic          hit;
  logic          free;
  logic [AW-1:0] free_slot;
  logic          cur_hit;
  logic          cur_free;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_sector, wr_start, wr_group, wr_size, wr_write};
    end
    rdata <= mem[ptr];
  end

  assign cur_hit  = chk && valid[rd_ptr] && rdata[EW-1 -: 64] == key;
  assign cur_free = chk && !valid[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      busy  <= 1'b0;
      chk   <= 1'b0;
      done  <= 1'b0;
      ptr   <= '0;
    end else begin
      done <= chk && !busy;
      if (wr_en) begin
        valid[wr_addr] <= wr_valid;
      end
      if (start) begin
        busy <= 1'b1;
        ptr  <= '0;
        hit  <= 1'b0;
        free <= 1'b0;
        chk  <= 1'b0;
      end else if (busy) begin
        chk    <= 1'b1;
        rd_ptr <= ptr;
        if (ptr != LAST) begin
          ptr <= ptr + 1'b1;
        end else begin
          busy <= 1'b0;
        end
      end else begin
        chk <= 1'b0;
      end
      if (chk) begin
        if (cur_hit && !hit) begin
          hit      <= 1'b1;
          slot     <= rd_ptr;
          rd_start <= rdata[EW-65 -: 64];
          rd_group <= rdata[EW-129 -: 64];
          rd_size  <= rdata[32:1];
          rd_write <= rdata[0];
        end
        if (cur_free && !free) begin
          free      <= 1'b1;
          free_slot <= rd_ptr;
        end
        if (!busy) begin
          if (!(cur_hit || hit) && (cur_free || free)) begin
            slot <= (cur_free && !free) ? rd_ptr : free_slot;
          end
        end
      end
    end
  end

  assign res.hit  = hit;
  assign res.free = free;

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("flight search done held");
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("flight search did not start");
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
      (done && hit) |-> valid[slot])
    else $error("flight hit on empty slot");

endmodule

// File: rtl/iolst_group.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iolst_group
// Group totals table: key search over a memory, then read-modify-write.
// ---------------------------------------------------------------------------
module iolst_group
  import iolst_pkg::*;
#(
  parameter int DEPTH = GROUP_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] key,
  input  logic        dir_write,
  input  logic [31:0] size,
  input  logic [63:0] lat,
  output logic        done,
  output logic        full,
  output logic [63:0] tot_bytes,
  output logic [63:0] tot_count,
  output logic [63:0] tot_lat
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam int TW = 6 * 64;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  logic [63:0]    keys [DEPTH];
  logic [TW-1:0]  tots [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [63:0]    krd;
  logic [TW-1:0]  trd;
  logic [2:0]     state;
  logic [AW-1:0]  ptr;
  logic [AW-1:0]  rd_ptr;
  logic           chk;
  logic           hit;
  logic           free;
  logic [AW-1:0]  hit_slot;
  logic [AW-1:0]  free_slot;
  logic           fresh;
  logic [AW-1:0]  addr;
  logic           wen;
  logic [TW-1:0]  wdata;
  logic [TW-1:0]  base;
  logic [63:0]    nb;
  logic [63:0]    nc;
  logic [63:0]    nl;
  logic           cur_hit;
  logic           cur_free;

  always_ff @(posedge clk) begin
    if (wen) begin
      keys[addr] <= key;
      tots[addr] <= wdata;
    end
    krd <= keys[ptr];
    trd <= tots[addr];
  end

  assign cur_hit  = chk && valid[rd_ptr] && krd == key;
  assign cur_free = chk && !valid[rd_ptr];

  // layout: rb wb rc wc rl wl
  always_comb begin
    base = fresh ? '0 : trd;
    if (dir_write) begin
      nb = base[319:256] + 64'(size);
      nc = base[191:128] + 64'd1;
      nl = base[63:0] + lat;
      wdata = {base[383:320], nb, base[255:192], nc, base[127:64], nl};
    end else begin
      nb = base[383:320] + 64'(size);
      nc = base[255:192] + 64'd1;
      nl = base[127:64] + lat;
      wdata = {nb, base[319:256], nc, base[191:128], nl, base[63:0]};
    end
  end

  assign wen = state == S_WRITE;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      state <= S_IDLE;
      done  <= 1'b0;
      chk   <= 1'b0;
      ptr   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= S_SCAN;
            ptr   <= '0;
            hit   <= 1'b0;
            free  <= 1'b0;
            chk   <= 1'b0;
          end
        end
        S_SCAN: begin
          rd_ptr <= ptr;
          if (ptr != LAST) begin
            ptr <= ptr + 1'b1;
            chk <= 1'b1;
          end else if (chk && rd_ptr == LAST) begin
            chk <= 1'b0;
          end else begin
            chk <= 1'b1;
          end
          if (cur_hit && !hit) begin
            hit      <= 1'b1;
            hit_slot <= rd_ptr;
          end
          if (cur_free && !free) begin
            free      <= 1'b1;
            free_slot <= rd_ptr;
          end
          if (chk && rd_ptr == LAST) begin
            if (cur_hit || hit) begin
              addr  <= (cur_hit && !hit) ? rd_ptr : hit_slot;
              fresh <= 1'b0;
              state <= S_READ;
            end else if (cur_free || free) begin
              addr  <= (cur_free && !free) ? rd_ptr : free_slot;
              fresh <= 1'b1;
              state <= S_READ;
            end else begin
              full  <= 1'b1;
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_READ:  state <= S_WAIT;
        S_WAIT:  state <= S_WRITE;
        S_WRITE: begin
          valid[addr] <= 1'b1;
          full      <= 1'b0;
          tot_bytes <= nb;
          tot_count <= nc;
          tot_lat   <= nl;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("group done held");
  a_write_valid: assert property (@(posedge clk) disable iff (rst) wen |=> valid[$past(addr)])
    else $error("written group not valid");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
      start |-> state == S_IDLE)
    else $error("group start while busy");

endmodule

// File: rtl/io_latency_stats_tracker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// io_latency_stats_tracker
// Per-group block I/O latency and byte totals from issue/completion words.
// ---------------------------------------------------------------------------
// An issue or an unmatched completion takes one key scan of the in-flight
// table; a matched completion then also scans the group table and does a
// read-modify-write of its totals (no write on a full group table). Both
// scans read one entry per cycle from the table memories. One word in
// flight at a time; the next is taken the cycle after the result is taken.
// Reset clears the valid bits of both tables at once; no clearing pass.
module io_latency_stats_tracker
  import iolst_pkg::*;
#(
  parameter int FLIGHT_DEPTH = FLIGHT_DEPTH_DEF,
  parameter int GROUP_DEPTH  = GROUP_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int FAW = (FLIGHT_DEPTH > 1) ? $clog2(FLIGHT_DEPTH) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FSCAN = 2'd1;
  localparam logic [1:0] S_GRP   = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]     state;
  in_word_t       cur;
  out_word_t      out_next;
  logic           f_start;
  logic           f_done;
  search_t        f_res;
  logic [FAW-1:0] f_slot;
  logic [63:0]    f_start_t;
  logic [63:0]    f_group;
  logic [31:0]    f_size;
  logic           f_write;
  logic           fw_en;
  logic           fw_valid;
  logic           g_start;
  logic           g_done;
  logic           g_full;
  logic [63:0]    g_bytes;
  logic [63:0]    g_count;
  logic [63:0]    g_lat;
  logic [63:0]    lat;
  logic [31:0]    issue_size;

  assign in_ready   = state == S_IDLE && !out_valid;
  assign f_start    = in_valid && in_ready;
  assign issue_size = 32'(cur.sector_count) << SECTOR_SHIFT;
  assign lat        = cur.now_ns - f_start_t;

  assign fw_en    = f_done && (cur.func == FUNC_ISSUE ? (f_res.hit || f_res.free) : f_res.hit);
  assign fw_valid = cur.func == FUNC_ISSUE;
  assign g_start  = f_done && cur.func == FUNC_COMPLETE && f_res.hit;

  iolst_flight #(.DEPTH(FLIGHT_DEPTH), .AW(FAW)) u_flight (
    .clk, .rst,
    .start(f_start), .key(f_start ? in_data.sector : cur.sector),
    .done(f_done), .res(f_res), .slot(f_slot),
    .rd_start(f_start_t), .rd_group(f_group), .rd_size(f_size), .rd_write(f_write),
    .wr_en(fw_en), .wr_valid(fw_valid), .wr_addr(f_slot),
    .wr_sector(cur.sector), .wr_start(cur.now_ns), .wr_group(cur.group_id),
    .wr_size(issue_size), .wr_write(cur.direction_char == WRITE_CHAR)
  );

  iolst_group #(.DEPTH(GROUP_DEPTH)) u_group (
    .clk, .rst,
    .start(g_start), .key(f_group), .dir_write(f_write), .size(f_size), .lat(lat),
    .done(g_done), .full(g_full),
    .tot_bytes(g_bytes), .tot_count(g_count), .tot_lat(g_lat)
  );

  always_comb begin
    out_next = '0;
    if (state == S_GRP) begin
      out_next.out_is_write = f_write;
      out_next.latency_ns   = lat;
      if (g_full) begin
        out_next.status = ST_GROUP_FULL;
      end else begin
        out_next.status           = ST_COMPLETED;
        out_next.out_group_id     = f_group;
        out_next.total_bytes      = g_bytes;
        out_next.total_count      = g_count;
        out_next.total_latency_ns = g_lat;
      end
    end else if (cur.func == FUNC_ISSUE) begin
      out_next.status = (f_res.hit || f_res.free) ? ST_ISSUED : ST_FLIGHT_FULL;
    end else begin
      out_next.status = ST_UNMATCHED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (f_start) begin
            cur   <= in_data;
            state <= S_FSCAN;
          end
        end
        S_FSCAN: begin
          if (f_done) begin
            if (cur.func == FUNC_ISSUE || !f_res.hit) begin
              out_data  <= out_next;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end else begin
              state <= S_GRP;
            end
          end
        end
        S_GRP: begin
          if (g_done) begin
            out_data  <= out_next;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
      (in_valid && in_ready) |=> !in_ready)
    else $error("accepted while busy");
  a_issue_flat: assert property (@(posedge clk) disable iff (rst)
      (out_valid && (out_data.status == ST_ISSUED || out_data.status == ST_UNMATCHED))
      |-> out_data.latency_ns == 64'd0)
    else $error("issue result not zeroed");
  a_grp_only_complete: assert property (@(posedge clk) disable iff (rst)
      g_start |-> cur.func == FUNC_COMPLETE)
    else $error("group update on issue");

endmodule

// File: tb/tb_io_latency_stats_tracker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_io_latency_stats_tracker
// Drives issue and completion words into the I/O latency tracker. A bench
// model of the in-flight and group tables predicts every result not fixed in
// a directed row. Directed rows cover the extremes, key overwrite, latency
// wrap and unmatched completions. Random bursts then fill the in-flight
// table and finally the group table, under varied idling on both sides.
// ---------------------------------------------------------------------------
module tb_io_latency_stats_tracker;
  import iolst_pkg::*;

  localparam int NFLIGHT = 64;
  localparam int NGROUP  = 64;
  localparam int NRAND   = 1125;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  int send_idle = 20;
  int recv_idle = 61;
  int errors = 0;
  int status_seen [5];

  out_word_t pending_results [$];

  // bench copy of the tables
  bit          fl_valid [NFLIGHT];
  logic [63:0] fl_sector [NFLIGHT];
  logic [63:0] fl_start [NFLIGHT];
  logic [63:0] fl_group [NFLIGHT];
  logic [31:0] fl_size [NFLIGHT];
  bit          fl_write [NFLIGHT];
  bit          gr_valid [NGROUP];
  logic [63:0] gr_key [NGROUP];
  logic [63:0] gr_bytes [NGROUP][2];
  logic [63:0] gr_count [NGROUP][2];
  logic [63:0] gr_lat [NGROUP][2];

  io_latency_stats_tracker u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  function automatic int flight_slot(logic [63:0] key);
    for (int i = 0; i < NFLIGHT; i++) begin
      if (fl_valid[i] && fl_sector[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic out_word_t track_event(in_word_t w);
    out_word_t r;
    int s;
    int g;
    int d;
    r = '0;
    s = flight_slot(w.sector);
    if (w.func == FUNC_ISSUE) begin
      if (s < 0) begin
        for (int i = NFLIGHT - 1; i >= 0; i--) begin
          if (!fl_valid[i]) s = i;
        end
      end
      if (s < 0) begin
        r.status = ST_FLIGHT_FULL;
        return r;
      end
      fl_valid[s]  = 1'b1;
      fl_sector[s] = w.sector;
      fl_start[s]  = w.now_ns;
      fl_group[s]  = w.group_id;
      fl_size[s]   = {w.sector_count, 9'd0};
      fl_write[s]  = (w.direction_char == WRITE_CHAR);
      r.status = ST_ISSUED;
      return r;
    end
    if (s < 0) begin
      r.status = ST_UNMATCHED;
      return r;
    end
    fl_valid[s] = 1'b0;
    r.out_is_write = fl_write[s];
    r.latency_ns = w.now_ns - fl_start[s];
    g = -1;
    for (int i = 0; i < NGROUP; i++) begin
      if (g < 0 && gr_valid[i] && gr_key[i] == fl_group[s]) g = i;
    end
    for (int i = 0; i < NGROUP; i++) begin
      if (g < 0 && !gr_valid[i]) begin
        g = i;
        gr_valid[i] = 1'b1;
        gr_key[i] = fl_group[s];
        for (int k = 0; k < 2; k++) begin
          gr_bytes[i][k] = '0;
          gr_count[i][k] = '0;
          gr_lat[i][k] = '0;
        end
      end
    end
    if (g < 0) begin
      r.status = ST_GROUP_FULL;
      return r;
    end
    d = fl_write[s];
    gr_bytes[g][d] += {32'd0, fl_size[s]};
    gr_count[g][d] += 64'd1;
    gr_lat[g][d] += r.latency_ns;
    r.status = ST_COMPLETED;
    r.out_group_id = fl_group[s];
    r.total_bytes = gr_bytes[g][d];
    r.total_count = gr_count[g][d];
    r.total_latency_ns = gr_lat[g][d];
    return r;
  endfunction

  task automatic send_word(in_word_t w, bit typed, out_word_t res);
    out_word_t p;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = w;
    do @(posedge clk); while (!in_ready);
    p = track_event(w);
    pending_results.push_back(typed ? res : p);
  endtask

  function automatic void cmp(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, e, a);
      errors++;
    end
  endfunction

  always @(negedge clk) begin
    out_ready = !rst && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    out_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, got %h", $time, out_data);
        errors++;
      end else begin
        e = pending_results.pop_front();
        cmp("status", e.status, out_data.status);
        cmp("out_group_id", e.out_group_id, out_data.out_group_id);
        cmp("out_is_write", e.out_is_write, out_data.out_is_write);
        cmp("latency_ns", e.latency_ns, out_data.latency_ns);
        cmp("total_bytes", e.total_bytes, out_data.total_bytes);
        cmp("total_count", e.total_count, out_data.total_count);
        cmp("total_latency_ns", e.total_latency_ns, out_data.total_latency_ns);
        if (out_data.status < 5) status_seen[out_data.status]++;
      end
    end
  end

  function automatic in_word_t mk(logic f, logic [63:0] sec, logic [63:0] gid,
                                  logic [22:0] cnt, logic [7:0] dir,
                                  logic [63:0] t);
    in_word_t w;
    w.func = f;
    w.sector = sec;
    w.group_id = gid;
    w.sector_count = cnt;
    w.direction_char = dir;
    w.now_ns = t;
    return w;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    #20ms;
    $display("tb_io_latency_stats_tracker failed");
    $finish;
  end

  initial begin
    row_t dir_rows [$];
    row_t r;
    out_word_t issued;
    out_word_t unmatched;
    in_word_t w;
    logic [63:0] clock_ns;
    logic [63:0] busy [$];
    int s;
    int phase;

    issued = '0;
    issued.status = ST_ISSUED;
    unmatched = '0;
    unmatched.status = ST_UNMATCHED;
    clock_ns = 64'd1000;

    r.typed = 1; r.res = unmatched;
    r.w = mk(FUNC_COMPLETE, '0, '1, '1, WRITE_CHAR, '0); dir_rows.push_back(r);
    r.res = issued;
    r.w = mk(FUNC_ISSUE, '0, '1, '1, WRITE_CHAR, '0); dir_rows.push_back(r);
    r.w = mk(FUNC_ISSUE, '1, '0, '0, 8'h00, '1); dir_rows.push_back(r);
    r.w = mk(FUNC_ISSUE, '0, 64'd5, 23'd1, "R", 64'd100); dir_rows.push_back(r);
    r.typed = 0;
    r.w = mk(FUNC_COMPLETE, '0, '0, '0, 8'h00, 64'd50); dir_rows.push_back(r);
    r.w = mk(FUNC_COMPLETE, '1, '1, '1, '1, 64'd5); dir_rows.push_back(r);
    r.typed = 1; r.res = unmatched;
    r.w = mk(FUNC_COMPLETE, '0, '0, '0, 8'h00, 64'd60); dir_rows.push_back(r);
    r.res = issued;
    r.w = mk(FUNC_ISSUE, 64'd7, 64'd5, 23'd8, WRITE_CHAR, 64'd10); dir_rows.push_back(r);
    r.typed = 0;
    r.w = mk(FUNC_COMPLETE, 64'd7, '0, '0, 8'h00, 64'd1000); dir_rows.push_back(r);
    r.w = mk(FUNC_ISSUE, 64'd7, 64'd5, 23'h7fffff, "w", 64'd20); dir_rows.push_back(r);
    r.w = mk(FUNC_COMPLETE, 64'd7, '0, '0, 8'h00, 64'd21); dir_rows.push_back(r);
    r.w = mk(FUNC_ISSUE, 64'd1, '1, 23'h400000, 8'hff, '0); dir_rows.push_back(r);
    r.w = mk(FUNC_COMPLETE, 64'd1, '0, '0, 8'h00, '1); dir_rows.push_back(r);
    r.w = mk(FUNC_ISSUE, 64'd2, 64'd5, 23'd3, WRITE_CHAR, 64'd30); dir_rows.push_back(r);
    r.w = mk(FUNC_COMPLETE, 64'd2, '0, '0, 8'h00, 64'd40); dir_rows.push_back(r);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);

    for (int n = 0; n < NRAND; n++) begin
      phase = n / (NRAND / 3);
      if (phase == 1) begin
        send_idle = 61; recv_idle = 20;
      end else if (phase >= 2) begin
        send_idle = 0; recv_idle = 0;
      end
      clock_ns += $urandom_range(5000);
      w.group_id = (phase < 2) ? 64'($urandom_range(40)) : rand64();
      if ($urandom_range(15) == 0) w.group_id = '1;
      w.sector_count = 23'($urandom());
      w.direction_char = $urandom_range(1) ? WRITE_CHAR : 8'($urandom());
      w.now_ns = ($urandom_range(19) == 0) ? rand64() : clock_ns;
      busy.delete();
      for (int i = 0; i < NFLIGHT; i++) begin
        if (fl_valid[i]) busy.push_back(fl_sector[i]);
      end
      if ($urandom_range(99) < (((n / 50) % 2 == 0) ? 85 : 25)) begin
        w.func = FUNC_ISSUE;
        s = $urandom_range(119);
        w.sector = (s == 0) ? '0 : (s == 1) ? '1 : (s < 100) ? 64'(s * 977) : rand64();
      end else begin
        w.func = FUNC_COMPLETE;
        if (busy.size() > 0 && $urandom_range(9) < 8) begin
          w.sector = busy[$urandom_range(busy.size() - 1)];
        end else begin
          w.sector = rand64();
        end
      end
      send_word(w, 1'b0, '0);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d words: %0d issued, %0d dropped on a full flight table,",
             dir_rows.size() + NRAND, status_seen[0], status_seen[1]);
    $display("%0d completed, %0d unmatched, %0d on a full group table; %0d mismatches.",
             status_seen[2], status_seen[3], status_seen[4], errors);
    if (errors == 0) begin
      $display("tb_io_latency_stats_tracker passed");
    end else begin
      $display("tb_io_latency_stats_tracker failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/iolst_pkg.sv
rtl/iolst_flight.sv
rtl/iolst_group.sv
rtl/io_latency_stats_tracker.sv
tb/tb_io_latency_stats_tracker.sv
